// ----- hdl/prq_pkg.sv -----
package prq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int PRIORITY_WIDTH = 8;

  // fixed field widths of the transactions
  localparam int ID_W        = 4;
  localparam int ID_COUNT    = 16;
  localparam int PRI_FIELD_W = 8;

  // derived storage widths
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [ID_W-1:0]        proc_id;
    logic [PRI_FIELD_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic                   ok;
    logic [ID_W-1:0]        removed_id;
    logic                   is_empty;
    logic [ID_W-1:0]        head_id;
    logic [PRI_FIELD_W-1:0] head_priority;
  } out_item_t;

  // one queue entry as stored in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [PRIORITY_WIDTH-1:0] pri;
  } slot_t;

endpackage

// ----- hdl/prq_in_if.sv -----
interface prq_in_if;
  logic               valid;
  logic               ready;
  prq_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/prq_out_if.sv -----
interface prq_out_if;
  logic               valid;
  logic               ready;
  prq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/priority_ready_queue.sv -----
// priority ready queue: process ids kept sorted by descending priority,
// first in, first out among equal priorities
// in_chan  : valid/ready command transaction (cmd, proc_id, priority_req)
// out_chan : valid/ready result transaction, exactly one per command
//            (ok, removed_id, is_empty, head_id, head_priority)
// entries live in a one-port-read, one-port-write slot memory with a
// registered read; a sorted insert walks from the tail moving entries up
// one slot per cycle, a removal walks from the head moving entries down
// sequence: clear, rejected commands and insert into an empty queue go
//   from idle straight to the response state; an insert into a non-empty
//   queue walks the tail in ST_INS, and ST_INS_FRONT if it passes every
//   entry; a removal walks every entry in ST_REM before the response
//   state registers the result into out_chan
// one command is worked at a time; in_chan.ready is high while idle, and
//   a finished result may still wait in the output register meanwhile
// reset clears the entry count and the per-id queued marks; the slot
//   memory is not cleared, only entries below the count are ever read
// while out_chan.ready is low the result holds and the next finished
//   result waits in the response state
module priority_ready_queue (
  input  logic      clk,
  input  logic      rst_n,
  prq_in_if.sink    in_chan,
  prq_out_if.source out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_FRONT,
    ST_REM,
    ST_RESP
  } state_t;

  // control
  state_t                               state_r;
  logic [prq_pkg::CNT_W-1:0]            count_r;
  logic [prq_pkg::ID_COUNT-1:0]         mark_r;
  logic [prq_pkg::IDX_W-1:0]            idx_r;
  logic                                 found_r;
  logic                                 out_valid_r;

  // latched command and result payload
  prq_pkg::cmd_t                        cmd_r;
  logic [prq_pkg::ID_W-1:0]             id_r;
  logic [prq_pkg::PRIORITY_WIDTH-1:0]   pri_r;
  logic                                 res_ok_r;
  logic [prq_pkg::ID_W-1:0]             rem_id_r;
  logic [prq_pkg::ID_W-1:0]             head_id_r;
  logic [prq_pkg::PRIORITY_WIDTH-1:0]   head_pri_r;
  prq_pkg::out_item_t                   out_data_r;

  // slot memory
  prq_pkg::slot_t                       slot_mem [prq_pkg::QUEUE_DEPTH];
  prq_pkg::slot_t                       rd_data_r;
  logic                                 rd_en;
  logic [prq_pkg::IDX_W-1:0]            rd_addr;
  logic                                 wr_en;
  logic [prq_pkg::IDX_W-1:0]            wr_addr;
  prq_pkg::slot_t                       wr_data;

  logic                                 in_fire;
  logic [prq_pkg::ID_W-1:0]             in_id;
  logic [prq_pkg::PRIORITY_WIDTH-1:0]   in_pri;
  logic                                 ins_ok;
  logic [prq_pkg::IDX_W-1:0]            last_idx;
  prq_pkg::slot_t                       new_slot;
  logic                                 shift_up;
  logic                                 match;
  logic [prq_pkg::ID_W-1:0]             rem_now;
  logic                                 is_empty;

  assign in_fire  = in_chan.valid && (state_r == ST_IDLE);
  assign in_id    = in_chan.data.proc_id;
  assign in_pri   = prq_pkg::PRIORITY_WIDTH'(in_chan.data.priority_req);
  assign ins_ok   = !mark_r[in_id] && (count_r != prq_pkg::CNT_W'(prq_pkg::QUEUE_DEPTH));
  // index of the tail entry, only used while the queue is not empty
  assign last_idx = prq_pkg::IDX_W'(count_r - prq_pkg::CNT_W'(1));
  assign new_slot = '{id: id_r, pri: pri_r};
  // new entry passes every tail entry of strictly lower priority
  assign shift_up = pri_r > rd_data_r.pri;
  assign match    = (cmd_r == prq_pkg::CMD_POP) ? (idx_r == '0) : (rd_data_r.id == id_r);
  assign rem_now  = found_r ? rem_id_r : rd_data_r.id;
  assign is_empty = (count_r == '0);

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.data.cmd)
            prq_pkg::CMD_INSERT: begin
              if (ins_ok) begin
                if (is_empty) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = '{id: in_id, pri: in_pri};
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = last_idx;
                end
              end
            end
            prq_pkg::CMD_POP: begin
              rd_en   = !is_empty;
              rd_addr = '0;
            end
            prq_pkg::CMD_REMOVE: begin
              rd_en   = mark_r[in_id];
              rd_addr = '0;
            end
            default: ;
          endcase
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + prq_pkg::IDX_W'(1);
        if (shift_up) begin
          wr_data = rd_data_r;
          rd_en   = (idx_r != '0);
          rd_addr = idx_r - prq_pkg::IDX_W'(1);
        end else begin
          wr_data = new_slot;
        end
      end
      ST_INS_FRONT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new_slot;
      end
      ST_REM: begin
        // entries behind the removed one move down a slot
        wr_en   = found_r;
        wr_addr = idx_r - prq_pkg::IDX_W'(1);
        wr_data = rd_data_r;
        rd_en   = (idx_r != last_idx);
        rd_addr = idx_r + prq_pkg::IDX_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      // a taken result drops valid unless the next one replaces it
      if (out_chan.ready && (state_r != ST_RESP)) begin
        out_valid_r <= 1'b0;
      end
      // head copy follows every write to the first slot
      if (wr_en && (wr_addr == '0)) begin
        head_id_r  <= wr_data.id;
        head_pri_r <= wr_data.pri;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_r    <= in_chan.data.cmd;
            id_r     <= in_id;
            pri_r    <= in_pri;
            found_r  <= 1'b0;
            rem_id_r <= '0;
            case (in_chan.data.cmd)
              prq_pkg::CMD_INSERT: begin
                if (ins_ok && !is_empty) begin
                  res_ok_r <= 1'b0;
                  idx_r    <= last_idx;
                  state_r  <= ST_INS;
                end else begin
                  res_ok_r <= ins_ok;
                  idx_r    <= '0;
                  state_r  <= ST_RESP;
                  if (ins_ok) begin
                    count_r       <= prq_pkg::CNT_W'(1);
                    mark_r[in_id] <= 1'b1;
                  end
                end
              end
              prq_pkg::CMD_POP: begin
                res_ok_r <= 1'b0;
                idx_r    <= '0;
                state_r  <= is_empty ? ST_RESP : ST_REM;
              end
              prq_pkg::CMD_REMOVE: begin
                res_ok_r <= 1'b0;
                idx_r    <= '0;
                state_r  <= mark_r[in_id] ? ST_REM : ST_RESP;
              end
              default: begin
                mark_r   <= '0;
                count_r  <= '0;
                res_ok_r <= 1'b1;
                idx_r    <= '0;
                state_r  <= ST_RESP;
              end
            endcase
          end
        end
        ST_INS: begin
          if (shift_up && (idx_r != '0)) begin
            idx_r <= idx_r - prq_pkg::IDX_W'(1);
          end else if (shift_up) begin
            state_r <= ST_INS_FRONT;
          end else begin
            count_r      <= count_r + prq_pkg::CNT_W'(1);
            mark_r[id_r] <= 1'b1;
            res_ok_r     <= 1'b1;
            state_r      <= ST_RESP;
          end
        end
        ST_INS_FRONT: begin
          count_r      <= count_r + prq_pkg::CNT_W'(1);
          mark_r[id_r] <= 1'b1;
          res_ok_r     <= 1'b1;
          state_r      <= ST_RESP;
        end
        ST_REM: begin
          if (idx_r == last_idx) begin
            count_r         <= count_r - prq_pkg::CNT_W'(1);
            mark_r[rem_now] <= 1'b0;
            rem_id_r        <= rem_now;
            res_ok_r        <= 1'b1;
            state_r         <= ST_RESP;
          end else begin
            if (!found_r && match) begin
              found_r  <= 1'b1;
              rem_id_r <= rd_data_r.id;
            end
            idx_r <= idx_r + prq_pkg::IDX_W'(1);
          end
        end
        ST_RESP: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.ok            <= res_ok_r;
            out_data_r.removed_id    <= rem_id_r;
            out_data_r.is_empty      <= is_empty;
            out_data_r.head_id       <= is_empty ? '0 : head_id_r;
            out_data_r.head_priority <= is_empty ? '0 : prq_pkg::PRI_FIELD_W'(head_pri_r);
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/prq_checker.sv -----
module prq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input prq_pkg::out_item_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one command worked at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // empty queue reports a zero head
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.head_id == '0 && out_data.head_priority == '0)
    else $error("empty queue with nonzero head");

  // failed commands remove nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.removed_id == '0)
    else $error("failed command reports a removed id");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

// ----- dv/tb_priority_ready_queue.sv -----
`timescale 1ns / 100ps

module tb_priority_ready_queue;

  // cycles without any accepted transaction before the run is declared hung
  localparam int STALL_LIMIT  = 3000;
  // long receiver hold that fills the block and stalls in_chan
  localparam int LONG_HOLD    = 300;
  // quiet cycles at the end, comfortably above the worst-case latency
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;

  prq_in_if  in_chan ();
  prq_out_if out_chan ();

  priority_ready_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow queue, ordered from the head
  logic [prq_pkg::ID_W-1:0]           shadow_id  [prq_pkg::QUEUE_DEPTH];
  logic [prq_pkg::PRIORITY_WIDTH-1:0] shadow_pri [prq_pkg::QUEUE_DEPTH];
  bit                                 shadow_queued [prq_pkg::ID_COUNT];
  int                                 shadow_count = 0;

  // results owed by the block, oldest first
  prq_pkg::out_item_t results_due [$];
  int                 error_count = 0;

  // sender burst bookkeeping
  int burst_left = 0;

  // receiver stall pattern state
  int hold_request = 0;
  int hold_left    = 0;
  int rx_cycle     = 0;
  int rx_mode      = 0;

  int idle_cycles = 0;

  // take one entry out of the shadow queue and close the gap
  function automatic void shadow_drop(int pos);
    shadow_queued[shadow_id[pos]] = 1'b0;
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_id[i]  = shadow_id[i + 1];
      shadow_pri[i] = shadow_pri[i + 1];
    end
    shadow_count--;
  endfunction

  // apply one command to the shadow queue and return the result it owes
  function automatic prq_pkg::out_item_t shadow_apply(prq_pkg::in_item_t cmd_item);
    prq_pkg::out_item_t                 res;
    int                                 pos;
    logic [prq_pkg::PRIORITY_WIDTH-1:0] pri;
    res = '0;
    pri = cmd_item.priority_req[prq_pkg::PRIORITY_WIDTH-1:0];
    case (cmd_item.cmd)
      prq_pkg::CMD_INSERT: begin
        // duplicates and a full queue are rejected, queue unchanged
        if (!shadow_queued[cmd_item.proc_id] && shadow_count < prq_pkg::QUEUE_DEPTH) begin
          pos = 0;
          // stop at the first strictly lower priority, ties stay fifo
          while (pos < shadow_count && !(pri > shadow_pri[pos])) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_id[i]  = shadow_id[i - 1];
            shadow_pri[i] = shadow_pri[i - 1];
          end
          shadow_id[pos]  = cmd_item.proc_id;
          shadow_pri[pos] = pri;
          shadow_queued[cmd_item.proc_id] = 1'b1;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      prq_pkg::CMD_POP: begin
        if (shadow_count > 0) begin
          res.removed_id = shadow_id[0];
          shadow_drop(0);
          res.ok = 1'b1;
        end
      end
      prq_pkg::CMD_REMOVE: begin
        if (shadow_queued[cmd_item.proc_id]) begin
          pos = 0;
          while (shadow_id[pos] != cmd_item.proc_id) pos++;
          shadow_drop(pos);
          res.removed_id = cmd_item.proc_id;
          res.ok = 1'b1;
        end
      end
      prq_pkg::CMD_CLEAR: begin
        foreach (shadow_queued[i]) shadow_queued[i] = 1'b0;
        shadow_count = 0;
        res.ok = 1'b1;
      end
    endcase
    res.is_empty = (shadow_count == 0);
    if (shadow_count != 0) begin
      res.head_id       = shadow_id[0];
      res.head_priority = prq_pkg::PRI_FIELD_W'(shadow_pri[0]);
    end
    return res;
  endfunction

  // drive one command transaction, wait for acceptance, then maybe open a gap
  task automatic send_cmd(prq_pkg::cmd_t cmd, logic [prq_pkg::ID_W-1:0] id,
                          logic [prq_pkg::PRI_FIELD_W-1:0] pri);
    prq_pkg::in_item_t item;
    int                gap;
    item.cmd          = cmd;
    item.proc_id      = id;
    item.priority_req = pri;
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.data  <= item;
    do @(posedge clk); while (!in_chan.ready);
    results_due.push_back(shadow_apply(item));
    burst_left--;
    if (burst_left <= 0) begin
      // mostly short bursts, now and then a long stretch with valid held high
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // one random command; removals mostly name an id that is queued
  task automatic send_random(int insert_pct);
    prq_pkg::cmd_t                   cmd;
    logic [prq_pkg::ID_W-1:0]        id;
    logic [prq_pkg::PRI_FIELD_W-1:0] pri;
    int                              roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) cmd = prq_pkg::CMD_INSERT;
    else if (roll < 97) cmd = ($urandom_range(0, 1) == 0) ? prq_pkg::CMD_POP : prq_pkg::CMD_REMOVE;
    else cmd = prq_pkg::CMD_CLEAR;
    id = prq_pkg::ID_W'($urandom_range(0, prq_pkg::ID_COUNT - 1));
    if (cmd == prq_pkg::CMD_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
      id = shadow_id[$urandom_range(0, shadow_count - 1)];
    // half the priorities come from a few values so ties are common
    if ($urandom_range(0, 1) == 0) pri = prq_pkg::PRI_FIELD_W'($urandom_range(0, 255));
    else pri = prq_pkg::PRI_FIELD_W'($urandom_range(0, 3) * 85);
    send_cmd(cmd, id, pri);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // removals and clear on an empty queue
  task automatic test_empty_queue();
    send_cmd(prq_pkg::CMD_POP, 4'd0, 8'd0);
    send_cmd(prq_pkg::CMD_REMOVE, 4'd15, 8'd255);
    send_cmd(prq_pkg::CMD_CLEAR, 4'd9, 8'd17);
  endtask

  // sorted placement, fifo among ties, duplicate insert, absent id
  task automatic test_sorted_insert();
    send_cmd(prq_pkg::CMD_INSERT, 4'd0, 8'd0);
    send_cmd(prq_pkg::CMD_INSERT, 4'd15, 8'd255);
    send_cmd(prq_pkg::CMD_INSERT, 4'd7, 8'd128);
    send_cmd(prq_pkg::CMD_INSERT, 4'd8, 8'd128);
    send_cmd(prq_pkg::CMD_INSERT, 4'd0, 8'd200);
    send_cmd(prq_pkg::CMD_REMOVE, 4'd8, 8'd0);
    send_cmd(prq_pkg::CMD_REMOVE, 4'd8, 8'd0);
    send_cmd(prq_pkg::CMD_POP, 4'd3, 8'd0);
    send_cmd(prq_pkg::CMD_POP, 4'd3, 8'd0);
    send_cmd(prq_pkg::CMD_POP, 4'd3, 8'd0);
    send_cmd(prq_pkg::CMD_POP, 4'd3, 8'd0);
  endtask

  // fill every slot, try one more, remove the tail entry, try another insert, then pop and clear
  task automatic test_full_queue();
    int base;
    base = $urandom_range(0, prq_pkg::ID_COUNT - 1);
    send_cmd(prq_pkg::CMD_CLEAR, 4'd0, 8'd0);
    // stepping by 7 mod 16 visits every id once
    for (int k = 0; k < prq_pkg::QUEUE_DEPTH; k++)
      send_cmd(prq_pkg::CMD_INSERT, prq_pkg::ID_W'((k * 7 + base) % prq_pkg::ID_COUNT),
               prq_pkg::PRI_FIELD_W'($urandom_range(0, 2) * 127 + $urandom_range(0, 1)));
    send_cmd(prq_pkg::CMD_INSERT, prq_pkg::ID_W'(base), 8'd255);
    send_cmd(prq_pkg::CMD_REMOVE, shadow_id[prq_pkg::QUEUE_DEPTH - 1], 8'd0);
    send_cmd(prq_pkg::CMD_INSERT, prq_pkg::ID_W'(base + 1), 8'd255);
    send_cmd(prq_pkg::CMD_POP, 4'd0, 8'd0);
    send_cmd(prq_pkg::CMD_CLEAR, 4'd0, 8'd0);
  endtask

  // receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    settle();
    hold_request = LONG_HOLD;
    repeat (24) send_random(70);
    settle();
  endtask

  // random traffic with a given share of inserts
  task automatic test_random_traffic(int count, int insert_pct);
    repeat (count) send_random(insert_pct);
  endtask

  // receiver: a long hold when asked, else one of four ready patterns picked at random
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= 1'($urandom_range(0, 1));
        2: out_chan.ready <= (rx_cycle % 4 != 0);
        default: out_chan.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result checker: each accepted result against the oldest owed one
  always @(posedge clk) begin
    prq_pkg::out_item_t due;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (results_due.size() == 0) begin
        $error("result transaction with no command outstanding");
        error_count++;
      end else begin
        due = results_due.pop_front();
        if (out_chan.data.ok !== due.ok) begin
          $error("ok: expected %0d, actual %0d", due.ok, out_chan.data.ok);
          error_count++;
        end
        if (out_chan.data.removed_id !== due.removed_id) begin
          $error("removed_id: expected %0d, actual %0d", due.removed_id,
                 out_chan.data.removed_id);
          error_count++;
        end
        if (out_chan.data.is_empty !== due.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", due.is_empty,
                 out_chan.data.is_empty);
          error_count++;
        end
        if (out_chan.data.head_id !== due.head_id) begin
          $error("head_id: expected %0d, actual %0d", due.head_id, out_chan.data.head_id);
          error_count++;
        end
        if (out_chan.data.head_priority !== due.head_priority) begin
          $error("head_priority: expected %0d, actual %0d", due.head_priority,
                 out_chan.data.head_priority);
          error_count++;
        end
      end
    end
  end

  // watchdog: ends the run once no transaction moves for too long
  initial begin
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_queue();
    test_sorted_insert();
    test_full_queue();
    test_backpressure();
    test_random_traffic(120, 50);
    test_random_traffic(120, 75);   // push toward a full queue
    test_random_traffic(100, 25);   // drain toward empty
    test_random_traffic(60, 50);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
